// ----- hw/rtl/bda_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds the controller states, the command and status bundles and fixed constants.
// No dependencies.
package bda_pkg;

   // Width of the number port and of one character code.
   localparam int unsigned NUMBER_PORT_WIDTH = 32;
   localparam int unsigned CHAR_WIDTH        = 6;
   localparam int unsigned BCD_DIGIT_WIDTH   = 4;

   // ASCII code of '0' in the character width.
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;

   // Double-dabble correction: digits of five or more get three added before the shift.
   localparam logic [BCD_DIGIT_WIDTH-1:0] BCD_ADJUST_LIMIT = 4'd5;
   localparam logic [BCD_DIGIT_WIDTH-1:0] BCD_ADJUST_ADD   = 4'd3;

   // Controller states.
   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_CONVERT,
      STATE_SKIP,
      STATE_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic convert_step;
      logic digit_shift;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic top_zero;
   } dp_status_type;

endpackage

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter: one unsigned number in, its decimal digits out,
// most significant first, leading zeros dropped, last marking the final digit.
// Sequence: one shift-add-3 step per number bit, then one skip per leading zero, then one
// strobe per digit. A new number is loaded only from idle, once the last digit is out.
// Results cannot be stalled. Reset returns to idle.
module binary_to_decimal_ascii import bda_pkg::*; #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [NUMBER_PORT_WIDTH-1:0]  req_number,
   output logic                          rsp_valid,
   output logic [CHAR_WIDTH-1:0]         rsp_char_code,
   output logic                          rsp_last
);

   // Decimal digits of the largest NUMBER_WIDTH-bit value (1233/4096 ~ log10 2).
   localparam int unsigned DIGIT_COUNT = ((NUMBER_WIDTH * 1233) >> 12) + 1;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing.
   bda_controller #(
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .DIGIT_COUNT  (DIGIT_COUNT)
   ) u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .valid  (rsp_valid),
      .last   (rsp_last)
   );

   // Conversion registers.
   bda_datapath #(
      .NUMBER_WIDTH (NUMBER_WIDTH),
      .DIGIT_COUNT  (DIGIT_COUNT)
   ) u_datapath (
      .clock     (clock),
      .number    (req_number),
      .cmd       (cmd),
      .status    (status),
      .char_code (rsp_char_code)
   );

endmodule

// ----- hw/rtl/bda_datapath.sv -----
// Datapath of the binary to decimal ASCII converter: binary shift register,
// BCD accumulator with shift-add-3 correction, and digit emission shift.
// Depends on bda_pkg.
module bda_datapath import bda_pkg::*; #(
   parameter int unsigned NUMBER_WIDTH = 32,
   parameter int unsigned DIGIT_COUNT  = 10
) (
   input  logic                          clock,
   input  logic [NUMBER_PORT_WIDTH-1:0]  number,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   output logic [CHAR_WIDTH-1:0]         char_code
);

   localparam int unsigned BCD_WIDTH = DIGIT_COUNT * BCD_DIGIT_WIDTH;

   logic [NUMBER_WIDTH-1:0] number_ext;
   logic [NUMBER_WIDTH-1:0] bin_ff;
   logic [NUMBER_WIDTH-1:0] bin_in;
   logic [BCD_WIDTH-1:0]    bcd_ff;
   logic [BCD_WIDTH-1:0]    bcd_in;
   logic [BCD_WIDTH-1:0]    bcd_adjusted;
   logic [BCD_DIGIT_WIDTH-1:0] top_digit;

   // Only the low NUMBER_WIDTH bits of the number are converted.
   generate
      if (NUMBER_WIDTH >= NUMBER_PORT_WIDTH) begin : g_extend
         assign number_ext = NUMBER_WIDTH'(number);
      end else begin : g_truncate
         assign number_ext = number[NUMBER_WIDTH-1:0];
      end
   endgenerate

   // Add three to every BCD digit that is five or more.
   always_comb begin
      for (int i = 0; i < int'(DIGIT_COUNT); i++) begin
         if (bcd_ff[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] >= BCD_ADJUST_LIMIT) begin
            bcd_adjusted[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] =
               bcd_ff[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] + BCD_ADJUST_ADD;
         end else begin
            bcd_adjusted[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH] =
               bcd_ff[i*BCD_DIGIT_WIDTH +: BCD_DIGIT_WIDTH];
         end
      end
   end

   // Next values of the binary and BCD registers.
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      priority if (cmd.load) begin
         bin_in = number_ext;
         bcd_in = '0;
      end else if (cmd.convert_step) begin
         bin_in = {bin_ff[NUMBER_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adjusted[BCD_WIDTH-2:0], bin_ff[NUMBER_WIDTH-1]};
      end else if (cmd.digit_shift) begin
         bcd_in = {bcd_ff[BCD_WIDTH-BCD_DIGIT_WIDTH-1:0], {BCD_DIGIT_WIDTH{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   // The most significant digit is the one on view.
   assign top_digit       = bcd_ff[BCD_WIDTH-1 -: BCD_DIGIT_WIDTH];
   assign status.top_zero = (top_digit == '0);
   assign char_code       = ASCII_ZERO + CHAR_WIDTH'(top_digit);

endmodule

// ----- hw/rtl/bda_controller.sv -----
// Controller of the binary to decimal ASCII converter: sequences the conversion
// steps, skips leading zero digits and strobes each digit out.
// Depends on bda_pkg.
module bda_controller import bda_pkg::*; #(
   parameter int unsigned NUMBER_WIDTH = 32,
   parameter int unsigned DIGIT_COUNT  = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy,
   output logic          valid,
   output logic          last
);

   localparam int unsigned BIT_CNT_WIDTH   = $clog2(NUMBER_WIDTH);
   localparam int unsigned DIGIT_CNT_WIDTH = $clog2(DIGIT_COUNT + 1);
   localparam logic [BIT_CNT_WIDTH-1:0]   LAST_BIT   = BIT_CNT_WIDTH'(NUMBER_WIDTH - 1);
   localparam logic [DIGIT_CNT_WIDTH-1:0] ALL_DIGITS = DIGIT_CNT_WIDTH'(DIGIT_COUNT);
   localparam logic [DIGIT_CNT_WIDTH-1:0] ONE_DIGIT  = DIGIT_CNT_WIDTH'(1);

   state_type                  state_ff;
   state_type                  state_in;
   logic [BIT_CNT_WIDTH-1:0]   bit_cnt_ff;
   logic [BIT_CNT_WIDTH-1:0]   bit_cnt_in;
   logic [DIGIT_CNT_WIDTH-1:0] digit_cnt_ff;
   logic [DIGIT_CNT_WIDTH-1:0] digit_cnt_in;
   logic                       final_bit;
   logic                       final_digit;

   assign final_bit   = (bit_cnt_ff == LAST_BIT);
   assign final_digit = (digit_cnt_ff == ONE_DIGIT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (start) state_in = STATE_CONVERT;
         end
         STATE_CONVERT: begin
            if (final_bit) state_in = STATE_SKIP;
         end
         STATE_SKIP: begin
            if (!status.top_zero || final_digit) state_in = STATE_EMIT;
         end
         STATE_EMIT: begin
            if (final_digit) state_in = STATE_IDLE;
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      cmd   = '0;
      busy  = 1'b1;
      valid = 1'b0;
      last  = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         STATE_CONVERT: begin
            cmd.convert_step = 1'b1;
         end
         STATE_SKIP: begin
            cmd.digit_shift = status.top_zero && !final_digit;
         end
         STATE_EMIT: begin
            valid           = 1'b1;
            last            = final_digit;
            cmd.digit_shift = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   // Bit and digit counters.
   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            bit_cnt_in = '0;
         end
         STATE_CONVERT: begin
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            digit_cnt_in = ALL_DIGITS;
         end
         STATE_SKIP: begin
            if (status.top_zero && !final_digit) digit_cnt_in = digit_cnt_ff - 1'b1;
         end
         STATE_EMIT: begin
            digit_cnt_in = digit_cnt_ff - 1'b1;
         end
         default: bit_cnt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff   <= bit_cnt_in;
      digit_cnt_ff <= digit_cnt_in;
   end

endmodule
